FILE: hdl/bounded_sequence_generator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bounded sequence generator checker
// Clocked, reset-qualified implication macros used by the port checker.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_SEQUENCE_GENERATOR_ASSERT_SVH
`define BOUNDED_SEQUENCE_GENERATOR_ASSERT_SVH

// Same-cycle implication: when a holds, b must hold at the same edge.
`define BSG_ASSERT_NOW(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication: when a holds, b must hold at the following edge.
`define BSG_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/bsg_pkg.sv
// ---------------------------------------------------------------------------
// bsg_pkg
// Shared types, codes and register reset values of the sequence generator.
// ---------------------------------------------------------------------------
package bsg_pkg;

  // Request codes.
  localparam logic [1:0] REQ_NEXT    = 2'd0;
  localparam logic [1:0] REQ_CURRENT = 2'd1;
  localparam logic [1:0] REQ_SET     = 2'd2;
  localparam logic [1:0] REQ_RESTART = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_BOUND = 3'd1;
  localparam logic [2:0] ST_UNDEF = 3'd2;
  localparam logic [2:0] ST_CACHE = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  // Register indexes (byte address is four times the index).
  localparam logic [2:0] REG_STEP  = 3'd0;
  localparam logic [2:0] REG_LOWER = 3'd1;
  localparam logic [2:0] REG_UPPER = 3'd2;
  localparam logic [2:0] REG_START = 3'd3;
  localparam logic [2:0] REG_WRAP  = 3'd4;
  localparam logic [2:0] REG_CACHE = 3'd5;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned CNT_W  = 16;

  localparam logic [31:0]      STEP_RST  = 32'd1;
  localparam logic [31:0]      LOWER_RST = 32'd1;
  localparam logic [31:0]      UPPER_RST = 32'h7FFF_FFFF;
  localparam logic [31:0]      START_RST = 32'd1;
  localparam logic [CNT_W-1:0] CACHE_RST = 16'd1;
  localparam logic [31:0]      STORED_RST = 32'd1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] set_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      step;
    logic [31:0]      lower_bound;
    logic [31:0]      upper_bound;
    logic [31:0]      start_value;
    logic             wrap_enable;
    logic [CNT_W-1:0] cache_size;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic start_refill;
    logic step_refill;
    logic commit_simple;
    logic commit_refill;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic miss;
    logic refill_done;
    logic slot_free;
  } sts_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_REFILL = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

FILE: hdl/bounded_sequence_generator.sv
// ---------------------------------------------------------------------------
// bounded_sequence_generator
// Sequence-number generator with signed step, bounds, wrap and a refill cache.
// ---------------------------------------------------------------------------
// One request is in flight at a time. A cached next value, a current-value,
// a set-value or a restart request is committed from the decide state once
// the output register is free. A next-value request that finds the cache
// empty runs a refill through a single 33-bit add-and-compare unit that
// reserves one value per cycle; up to cache_size - 1 following next requests
// are then cache hits. A finished result waits in the output register until
// it is taken. The user must write configuration through the APB-style port
// only while no request is in flight; the block does not enforce this.
// ---------------------------------------------------------------------------
module bounded_sequence_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bsg_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bsg_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  bsg_pkg::cfg_t cfg;
  bsg_pkg::cmd_t cmd;
  bsg_pkg::sts_t sts;

  bsg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bsg_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hdl/bsg_regs.sv
// ---------------------------------------------------------------------------
// bsg_regs
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
module bsg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output bsg_pkg::cfg_t               cfg
);

  bsg_pkg::cfg_t cfg_r;
  bsg_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[bsg_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        bsg_pkg::REG_STEP:  cfg_nxt.step        = pwdata;
        bsg_pkg::REG_LOWER: cfg_nxt.lower_bound = pwdata;
        bsg_pkg::REG_UPPER: cfg_nxt.upper_bound = pwdata;
        bsg_pkg::REG_START: cfg_nxt.start_value = pwdata;
        bsg_pkg::REG_WRAP:  cfg_nxt.wrap_enable = pwdata[0];
        bsg_pkg::REG_CACHE: cfg_nxt.cache_size  = pwdata[bsg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bsg_pkg::REG_STEP:  prdata = cfg_r.step;
      bsg_pkg::REG_LOWER: prdata = cfg_r.lower_bound;
      bsg_pkg::REG_UPPER: prdata = cfg_r.upper_bound;
      bsg_pkg::REG_START: prdata = cfg_r.start_value;
      bsg_pkg::REG_WRAP:  prdata = {31'd0, cfg_r.wrap_enable};
      bsg_pkg::REG_CACHE: prdata = {{(32-bsg_pkg::CNT_W){1'b0}}, cfg_r.cache_size};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step        <= bsg_pkg::STEP_RST;
      cfg_r.lower_bound <= bsg_pkg::LOWER_RST;
      cfg_r.upper_bound <= bsg_pkg::UPPER_RST;
      cfg_r.start_value <= bsg_pkg::START_RST;
      cfg_r.wrap_enable <= 1'b0;
      cfg_r.cache_size  <= bsg_pkg::CACHE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: hdl/bsg_ctrl.sv
// ---------------------------------------------------------------------------
// bsg_ctrl
// Request sequencer: accepts a request, runs the refill loop, retires it.
// ---------------------------------------------------------------------------
module bsg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bsg_pkg::sts_t sts,
  output bsg_pkg::cmd_t cmd
);

  bsg_pkg::state_t state_r;
  bsg_pkg::state_t state_nxt;

  assign in_ready = (state_r == bsg_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bsg_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bsg_pkg::S_DECIDE;
        end
      end
      bsg_pkg::S_DECIDE: begin
        if (sts.miss) begin
          cmd.start_refill = 1'b1;
          state_nxt        = bsg_pkg::S_REFILL;
        end else if (sts.slot_free) begin
          cmd.commit_simple = 1'b1;
          state_nxt         = bsg_pkg::S_IDLE;
        end
      end
      bsg_pkg::S_REFILL: begin
        if (sts.refill_done) begin
          state_nxt = bsg_pkg::S_FINISH;
        end else begin
          cmd.step_refill = 1'b1;
        end
      end
      bsg_pkg::S_FINISH: begin
        if (sts.slot_free) begin
          cmd.commit_refill = 1'b1;
          state_nxt         = bsg_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/bsg_dpath.sv
// ---------------------------------------------------------------------------
// bsg_dpath
// Sequence state, one-reservation-per-cycle refill unit and result register.
// ---------------------------------------------------------------------------
module bsg_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  bsg_pkg::cfg_t      cfg,
  input  bsg_pkg::in_item_t  in_data,
  input  bsg_pkg::cmd_t      cmd,
  output bsg_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_ready,
  output bsg_pkg::out_item_t out_data
);

  localparam int unsigned CW = bsg_pkg::CNT_W;

  logic [1:0]    req_r, req_nxt;
  logic [31:0]   setv_r, setv_nxt;
  logic [31:0]   stored_r, stored_nxt;
  logic [31:0]   handed_r, handed_nxt;
  logic [31:0]   reserved_r, reserved_nxt;
  logic          called_r, called_nxt;
  logic          defined_r, defined_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [31:0]   res_r, res_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          stop_r, stop_nxt;
  logic          err_r, err_nxt;
  logic          out_valid_r, out_valid_nxt;
  bsg_pkg::out_item_t out_r, out_nxt;

  logic [CW-1:0]      lim;
  logic               step_pos;
  logic signed [32:0] sum;
  logic               hit;
  logic [31:0]        adv;
  logic [31:0]        hop;

  // A zero cache size behaves as one.
  assign lim = (cfg.cache_size == '0) ? CW'(1) : cfg.cache_size;

  // Bound check in 33 bits so that the step cannot overflow past a bound.
  // A zero step counts as descending.
  assign step_pos = !cfg.step[31] && (cfg.step != 32'd0);
  assign sum      = $signed({cur_r[31], cur_r}) + $signed({cfg.step[31], cfg.step});
  assign hit      = step_pos ? (sum > $signed({cfg.upper_bound[31], cfg.upper_bound}))
                             : (sum < $signed({cfg.lower_bound[31], cfg.lower_bound}));
  assign hop      = step_pos ? cfg.lower_bound : cfg.upper_bound;
  assign adv      = handed_r + cfg.step;

  assign sts.miss        = (req_r == bsg_pkg::REQ_NEXT) && (handed_r == reserved_r);
  assign sts.refill_done = stop_r || (cnt_r >= lim);
  assign sts.slot_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    req_nxt       = req_r;
    setv_nxt      = setv_r;
    stored_nxt    = stored_r;
    handed_nxt    = handed_r;
    reserved_nxt  = reserved_r;
    called_nxt    = called_r;
    defined_nxt   = defined_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    stop_nxt      = stop_r;
    err_nxt       = err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.capture) begin
      req_nxt  = in_data.req_type;
      setv_nxt = in_data.set_value;
    end

    if (cmd.start_refill) begin
      defined_nxt = 1'b1;
      cur_nxt     = stored_r;
      res_nxt     = stored_r;
      // A stored value not yet handed out is itself the first reservation.
      cnt_nxt     = called_r ? CW'(0) : CW'(1);
      stop_nxt    = 1'b0;
      err_nxt     = 1'b0;
    end

    if (cmd.step_refill) begin
      if (hit && (cnt_r != '0)) begin
        stop_nxt = 1'b1;
      end else if (hit && !cfg.wrap_enable) begin
        stop_nxt = 1'b1;
        err_nxt  = 1'b1;
      end else begin
        cur_nxt = hit ? hop : sum[31:0];
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == '0) begin
          res_nxt = hit ? hop : sum[31:0];
        end
      end
    end

    if (cmd.commit_simple) begin
      out_valid_nxt = 1'b1;
      case (req_r)
        bsg_pkg::REQ_NEXT: begin
          handed_nxt = adv;
          out_nxt    = '{value: adv, status: bsg_pkg::ST_OK};
        end
        bsg_pkg::REQ_CURRENT: begin
          if (!defined_r) begin
            out_nxt = '{value: 32'd0, status: bsg_pkg::ST_UNDEF};
          end else begin
            out_nxt = '{value: handed_r, status: bsg_pkg::ST_OK};
          end
        end
        bsg_pkg::REQ_SET: begin
          defined_nxt = 1'b1;
          if (lim != CW'(1)) begin
            out_nxt = '{value: 32'd0, status: bsg_pkg::ST_CACHE};
          end else if (($signed(setv_r) < $signed(cfg.lower_bound)) ||
                       ($signed(setv_r) > $signed(cfg.upper_bound))) begin
            out_nxt = '{value: 32'd0, status: bsg_pkg::ST_RANGE};
          end else begin
            handed_nxt   = setv_r;
            reserved_nxt = setv_r;
            stored_nxt   = setv_r;
            called_nxt   = 1'b1;
            out_nxt      = '{value: setv_r, status: bsg_pkg::ST_OK};
          end
        end
        default: begin
          // Restart drops any cached numbers.
          stored_nxt   = cfg.start_value;
          called_nxt   = 1'b0;
          reserved_nxt = handed_r;
          out_nxt      = '{value: cfg.start_value, status: bsg_pkg::ST_OK};
        end
      endcase
    end

    if (cmd.commit_refill) begin
      out_valid_nxt = 1'b1;
      if (err_r) begin
        out_nxt = '{value: 32'd0, status: bsg_pkg::ST_BOUND};
      end else begin
        handed_nxt   = res_r;
        reserved_nxt = cur_r;
        stored_nxt   = cur_r;
        called_nxt   = 1'b1;
        out_nxt      = '{value: res_r, status: bsg_pkg::ST_OK};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r    <= bsg_pkg::STORED_RST;
      handed_r    <= 32'd0;
      reserved_r  <= 32'd0;
      called_r    <= 1'b0;
      defined_r   <= 1'b0;
      out_valid_r <= 1'b0;
      stop_r      <= 1'b0;
      err_r       <= 1'b0;
      cnt_r       <= '0;
    end else begin
      stored_r    <= stored_nxt;
      handed_r    <= handed_nxt;
      reserved_r  <= reserved_nxt;
      called_r    <= called_nxt;
      defined_r   <= defined_nxt;
      out_valid_r <= out_valid_nxt;
      stop_r      <= stop_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    setv_r <= setv_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: hdl/bsg_checker.sv
// ---------------------------------------------------------------------------
// bsg_checker
// Port-level checks of the sequence generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "bounded_sequence_generator_assert.svh"

module bsg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input bsg_pkg::out_item_t out_data
);

  // A result that is not taken stays on the port unchanged.
  `BSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

  // Every failing request reports a zero value.
  `BSG_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_data.status != bsg_pkg::ST_OK), out_data.value == 32'd0, "error result with nonzero value")

  // Only the defined status codes appear.
  `BSG_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, out_data.status <= bsg_pkg::ST_RANGE, "undefined status code")

  // Requests are handled one at a time, so a transfer closes the input side.
  `BSG_ASSERT_NEXT(a_one_inflight, clk, rst_n, in_valid && in_ready, !in_ready, "second request taken while one is in flight")

endmodule

bind bounded_sequence_generator bsg_checker u_bsg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
